[sv/act_pkg.sv]
// Shared constants for the adaptive correspondence threshold block.
package act_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MOTION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_WEIGHT = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] RST_INIT_LEVEL     = 32'd65536;
  localparam logic [31:0] RST_MIN_MOTION     = 32'd13107;
  localparam logic [31:0] RST_RANGE_SCALE    = 32'd6553600;
  localparam logic [15:0] RST_AVERAGE_WEIGHT = 16'd0;

  // Unity weight in Q1.16
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

endpackage

[sv/act_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
module act_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

[sv/act_isqrt.sv]
// Iterative 64-bit integer square root, two radicand bits per cycle.
module act_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] val;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  assign rem_sh = {rem[32:0], val[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        val <= {val[61:0], 2'b00};
        if (ge) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/act_div.sv]
// Iterative 64 by 32 unsigned restoring divider, one quotient bit per cycle.
module act_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic [31:0] dvs;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] diff;

  assign rem_sh = {rem, quot[63]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem  <= ge ? diff[31:0] : rem_sh[31:0];
        quot <= {quot[62:0], ge};
        cnt  <= cnt + 6'd1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/adaptive_correspondence_threshold.sv]
// Top level: sequencer for the adaptive correspondence threshold.
// Each item takes two square roots, of the translation norm and the doubled rotation norm;
//   once a sample is held, a divide and a third root give the running mean, or a third
//   root alone the exponential average; before any sample the initial level is returned.
// One item at a time: in_ready is high only in idle, reentered once the result is loaded.
// Reset (rst, synchronous): registers take their defaults, sum and count clear.
module adaptive_correspondence_threshold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [act_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [act_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           trans_x,
  input  logic signed [31:0]           trans_y,
  input  logic signed [31:0]           trans_z,
  input  logic signed [15:0]           rot_x,
  input  logic signed [15:0]           rot_y,
  input  logic signed [15:0]           rot_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  threshold,
  output logic                         sample_taken
);

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MTX   = 5'd1;
  localparam logic [4:0] S_MTY   = 5'd2;
  localparam logic [4:0] S_MTZ   = 5'd3;
  localparam logic [4:0] S_MQX   = 5'd4;
  localparam logic [4:0] S_MQY   = 5'd5;
  localparam logic [4:0] S_MQZ   = 5'd6;
  localparam logic [4:0] S_QSUM  = 5'd7;
  localparam logic [4:0] S_TSQRT = 5'd8;
  localparam logic [4:0] S_QSQRT = 5'd9;
  localparam logic [4:0] S_DROT  = 5'd10;
  localparam logic [4:0] S_ERR   = 5'd11;
  localparam logic [4:0] S_E2    = 5'd12;
  localparam logic [4:0] S_PREV  = 5'd13;
  localparam logic [4:0] S_EMA0  = 5'd14;
  localparam logic [4:0] S_EMA1  = 5'd15;
  localparam logic [4:0] S_EMA2  = 5'd16;
  localparam logic [4:0] S_EMA3  = 5'd17;
  localparam logic [4:0] S_EMA4  = 5'd18;
  localparam logic [4:0] S_THR   = 5'd19;
  localparam logic [4:0] S_DIV   = 5'd20;
  localparam logic [4:0] S_RSQRT = 5'd21;
  localparam logic [4:0] S_DONE  = 5'd22;

  // Configuration registers
  logic [31:0] init_level;
  logic [31:0] min_motion;
  logic [31:0] range_scale;
  logic [15:0] average_weight;

  // Accumulator state
  logic [63:0] error_square_acc;
  logic [31:0] sample_count;

  // Working registers
  logic [4:0]  state;
  logic [31:0] tx, ty, tz;
  logic [15:0] qx, qy, qz;
  logic [63:0] t0;        // translation square sum, later EMA high part
  logic [63:0] t1;        // rotation square sum, later EMA low part
  logic [31:0] tnorm;
  logic [34:0] err;
  logic [63:0] e2;
  logic [63:0] prev;
  logic        taken;
  logic [31:0] res_thr;

  // Shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sq_start, sq_done;
  logic [63:0] sq_op;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [63:0] dv_quot;

  logic        ema;
  logic [16:0] wa;
  logic [34:0] err_next;
  logic [31:0] es;
  logic [64:0] sum_next;
  logic [31:0] count_next;
  logic        count_full;
  logic [63:0] ema_lo;

  assign ema        = average_weight != 16'd0;
  assign wa         = act_pkg::WEIGHT_ONE - {1'b0, average_weight};
  // Rotation error is range * 2|q| >> 15, kept to 34 bits; the product lands while in S_DROT
  assign err_next   = {3'd0, tnorm} + {1'b0, mul_p[48:15]};
  assign es         = (err[34:32] != 3'd0) ? '1 : err[31:0];
  assign sum_next   = {1'b0, error_square_acc} + {1'b0, e2};
  assign count_full = sample_count == '1;
  assign count_next = count_full ? sample_count : sample_count + 32'd1;
  assign ema_lo     = t1 + mul_p;

  assign in_ready = state == S_IDLE;

  act_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  act_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  act_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (error_square_acc),
    .divisor  (sample_count),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  // Multiplier operand selection; the product is registered and appears in the following cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MTX:  begin mul_a = tx; mul_b = tx; end
      S_MTY:  begin mul_a = ty; mul_b = ty; end
      S_MTZ:  begin mul_a = tz; mul_b = tz; end
      S_MQX:  begin mul_a = {16'd0, qx}; mul_b = {16'd0, qx}; end
      S_MQY:  begin mul_a = {16'd0, qy}; mul_b = {16'd0, qy}; end
      S_MQZ:  begin mul_a = {16'd0, qz}; mul_b = {16'd0, qz}; end
      S_QSQRT: begin mul_a = range_scale; mul_b = sq_root; end
      S_ERR:  begin mul_a = es; mul_b = es; end
      S_E2:   begin mul_a = init_level; mul_b = init_level; end
      S_EMA0: begin mul_a = {15'd0, wa}; mul_b = prev[63:32]; end
      S_EMA1: begin mul_a = {16'd0, average_weight}; mul_b = e2[63:32]; end
      S_EMA2: begin mul_a = {15'd0, wa}; mul_b = prev[31:0]; end
      S_EMA3: begin mul_a = {16'd0, average_weight}; mul_b = e2[31:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Square root start and operand
  always_comb begin
    sq_start = 1'b0;
    sq_op    = t0;
    case (state)
      S_QSUM:  begin sq_start = 1'b1; sq_op = t0; end
      S_TSQRT: begin sq_start = sq_done; sq_op = {t1[61:0], 2'b00}; end
      S_THR:   begin sq_start = (sample_count != '0) && ema; sq_op = error_square_acc; end
      S_DIV:   begin sq_start = dv_done; sq_op = dv_quot; end
      default: begin sq_start = 1'b0; sq_op = t0; end
    endcase
  end

  assign dv_start = (state == S_THR) && (sample_count != '0) && !ema;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_level     <= act_pkg::RST_INIT_LEVEL;
      min_motion     <= act_pkg::RST_MIN_MOTION;
      range_scale    <= act_pkg::RST_RANGE_SCALE;
      average_weight <= act_pkg::RST_AVERAGE_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        act_pkg::REG_INIT_LEVEL:     init_level     <= cfg_data;
        act_pkg::REG_MIN_MOTION:     min_motion     <= cfg_data;
        act_pkg::REG_RANGE_SCALE:    range_scale    <= cfg_data;
        act_pkg::REG_AVERAGE_WEIGHT: average_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      error_square_acc <= '0;
      sample_count     <= '0;
      out_valid        <= 1'b0;
    end else begin
      // Drop the result after its transfer unless a new one loads now
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // Take magnitudes on transfer
            tx    <= trans_x[31] ? 32'd0 - trans_x : trans_x;
            ty    <= trans_y[31] ? 32'd0 - trans_y : trans_y;
            tz    <= trans_z[31] ? 32'd0 - trans_z : trans_z;
            qx    <= rot_x[15] ? 16'd0 - rot_x : rot_x;
            qy    <= rot_y[15] ? 16'd0 - rot_y : rot_y;
            qz    <= rot_z[15] ? 16'd0 - rot_z : rot_z;
            state <= S_MTX;
          end
        end
        S_MTX: state <= S_MTY;
        S_MTY: begin
          t0    <= mul_p;
          state <= S_MTZ;
        end
        S_MTZ: begin
          t0    <= t0 + mul_p;
          state <= S_MQX;
        end
        S_MQX: begin
          t0    <= t0 + mul_p;
          state <= S_MQY;
        end
        S_MQY: begin
          t1    <= mul_p;
          state <= S_MQZ;
        end
        S_MQZ: begin
          t1    <= t1 + mul_p;
          state <= S_QSUM;
        end
        S_QSUM: begin
          // Translation root starts now; fold qz^2 into the rotation sum
          t1    <= t1 + mul_p;
          state <= S_TSQRT;
        end
        S_TSQRT: begin
          if (sq_done) begin
            tnorm <= sq_root;
            state <= S_QSQRT;
          end
        end
        S_QSQRT: begin
          if (sq_done) begin
            state <= S_DROT;
          end
        end
        S_DROT: begin
          err   <= err_next;
          taken <= err_next > {3'd0, min_motion};
          state <= S_ERR;
        end
        S_ERR: state <= taken ? S_E2 : S_THR;
        S_E2: begin
          // Square of the saturated error lands here
          e2    <= mul_p;
          state <= S_PREV;
        end
        S_PREV: begin
          // First average sample starts from the initial threshold squared
          prev <= (sample_count == '0) ? mul_p : error_square_acc;
          if (ema) begin
            state <= S_EMA0;
          end else begin
            error_square_acc <= sum_next[64] ? '1 : sum_next[63:0];
            sample_count     <= count_next;
            state            <= S_THR;
          end
        end
        S_EMA0: state <= S_EMA1;
        S_EMA1: begin
          t0    <= mul_p;
          state <= S_EMA2;
        end
        S_EMA2: begin
          t0    <= t0 + mul_p;
          state <= S_EMA3;
        end
        S_EMA3: begin
          t1    <= mul_p;
          state <= S_EMA4;
        end
        S_EMA4: begin
          error_square_acc <= {t0[47:0], 16'd0} + {16'd0, ema_lo[63:16]};
          sample_count     <= count_next;
          state            <= S_THR;
        end
        S_THR: begin
          if (sample_count == '0) begin
            res_thr <= init_level;
            state   <= S_DONE;
          end else if (ema) begin
            state <= S_RSQRT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            state <= S_RSQRT;
          end
        end
        S_RSQRT: begin
          if (sq_done) begin
            res_thr <= sq_root;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (!out_valid || out_ready) begin
            threshold    <= res_thr;
            sample_taken <= taken;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/act_checker.sv]
`timescale 1ns / 1ps
// Checker: watches both channels, predicts each threshold result and compares.
module act_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [15:0] rot_x,
  input  logic signed [15:0] rot_y,
  input  logic signed [15:0] rot_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        threshold,
  input  logic               sample_taken,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] thr;
    logic        taken;
  } thr_result_t;

  logic [31:0] init_thr, min_mot, range_m;
  logic [15:0] weight;
  logic [63:0] sq_acc;
  logic [31:0] n_samples;
  thr_result_t expected_q[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs32(logic signed [31:0] v);
    return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
  endfunction

  function automatic logic [63:0] abs16(logic signed [15:0] v);
    return v[15] ? 64'h1_0000 - {48'd0, v} : {48'd0, v};
  endfunction

  // Advance the accumulator by one deviation and return the threshold result.
  function automatic thr_result_t next_threshold(logic signed [31:0] tx, ty, tz,
                                                 logic signed [15:0] qx, qy, qz);
    logic [63:0] ax, ay, az, bx, by, bz, tn, qn, err, es, e2, prev, s, wa, hi, lo, rt;
    logic [95:0] drot;
    thr_result_t res;
    ax = abs32(tx); ay = abs32(ty); az = abs32(tz);
    bx = abs16(qx); by = abs16(qy); bz = abs16(qz);
    tn = root64(ax * ax + ay * ay + az * az);
    qn = root64((bx * bx + by * by + bz * bz) << 2);
    drot = ({64'd0, range_m} * {32'd0, qn}) >> 15;
    err = tn + drot[63:0];
    res.taken = err > {32'd0, min_mot};
    if (res.taken) begin
      es = (err > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : err;
      e2 = es * es;
      if (weight != 0) begin
        prev = (n_samples == 0) ? {32'd0, init_thr} * {32'd0, init_thr} : sq_acc;
        wa = 64'd65536 - weight;
        hi = wa * (prev >> 32) + weight * (e2 >> 32);
        lo = wa * (prev & 64'hFFFF_FFFF) + weight * (e2 & 64'hFFFF_FFFF);
        sq_acc = (hi << 16) + (lo >> 16);
      end else begin
        s = sq_acc + e2;
        sq_acc = (s < e2) ? '1 : s;
      end
      if (n_samples != 32'hFFFF_FFFF) n_samples++;
    end
    if (n_samples == 0) begin
      res.thr = init_thr;
    end else begin
      if (weight != 0) rt = root64(sq_acc);
      else rt = root64(sq_acc / n_samples);
      res.thr = rt[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    thr_result_t exp_r;
    thr_result_t pred_r;
    if (rst) begin
      init_thr <= act_pkg::RST_INIT_LEVEL;
      min_mot <= act_pkg::RST_MIN_MOTION;
      range_m <= act_pkg::RST_RANGE_SCALE;
      weight <= act_pkg::RST_AVERAGE_WEIGHT;
      sq_acc = 0;
      n_samples = 0;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          act_pkg::REG_INIT_LEVEL:     init_thr <= cfg_data;
          act_pkg::REG_MIN_MOTION:     min_mot <= cfg_data;
          act_pkg::REG_RANGE_SCALE:    range_m <= cfg_data;
          act_pkg::REG_AVERAGE_WEIGHT: weight <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred_r = next_threshold(trans_x, trans_y, trans_z, rot_x, rot_y, rot_z);
        expected_q = {expected_q, pred_r};
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result thr=%h taken=%b", $time, threshold, sample_taken);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.thr !== threshold || exp_r.taken !== sample_taken) begin
            $display("%0t: mismatch expected thr=%h taken=%b actual thr=%h taken=%b",
                     $time, exp_r.thr, exp_r.taken, threshold, sample_taken);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, configuration, deviation stimulus and verdict.
module testbench;

  logic clk, rst;
  logic cfg_we;
  logic [act_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [act_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready, sample_taken;
  logic signed [31:0] trans_x, trans_y, trans_z;
  logic signed [15:0] rot_x, rot_y, rot_z;
  logic [31:0] threshold;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;

  adaptive_correspondence_threshold dut (.*);

  act_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Hard stop: all 440 items fit well inside this.
  initial begin
    #50ms;
    $display("adaptive_correspondence_threshold test failed");
    $finish;
  end

  // Receiver: stall out_ready at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Write one register at an edge; block must be idle.
  task automatic write_reg(logic [act_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the input, wait for every expected transfer, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Present one deviation and hold it until the transfer happens.
  task automatic send_dev(logic [31:0] tx, ty, tz, logic [15:0] qx, qy, qz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    trans_x <= tx; trans_y <= ty; trans_z <= tz;
    rot_x <= qx; rot_y <= qy; rot_z <= qz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random deviation; mix of small motions near the threshold and full-range values.
  task automatic send_random();
    logic [31:0] t[3];
    logic [15:0] q[3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: t[k] = $urandom;
        1: t[k] = $urandom_range(65535) - 32768;
        default: t[k] = $urandom_range(1 << 20) - (1 << 19);
      endcase
      case ($urandom_range(3))
        0: q[k] = 16'($urandom);
        1: q[k] = 16'd0;
        default: q[k] = 16'($urandom_range(400) - 200);
      endcase
    end
    send_dev(t[0], t[1], t[2], q[0], q[1], q[2]);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0;
    trans_x = 0; trans_y = 0; trans_z = 0;
    rot_x = 0; rot_y = 0; rot_z = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, no sample yet, then extremes and non-unit quaternions.
    send_dev(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    send_dev(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_dev(32'd20000, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    send_dev(32'd20000, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    send_dev(32'hFFFF_FFFF, 32'd1, 32'hFFFF_0000, 16'hFFFF, 16'd1, 16'd0);
    send_dev(32'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000);
    drain();
    // Huge range and zero motion floor: saturate the running sum.
    write_reg(act_pkg::REG_RANGE_SCALE, 32'hFFFF_FFFF);
    write_reg(act_pkg::REG_MIN_MOTION, 32'd0);
    repeat (6) send_dev(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'h8000, 16'h8000, 16'h8000);
    send_dev(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    drain();
    // Switch to exponential average with the store as it stands.
    write_reg(act_pkg::REG_AVERAGE_WEIGHT, 32'hFFFF);
    send_dev(32'd65536, 32'd0, 32'd0, 16'd0, 16'd0, 16'd1);
    drain();
    write_reg(act_pkg::REG_AVERAGE_WEIGHT, 32'd1);
    send_dev(32'd65536, 32'd5, 32'd0, 16'd3, 16'd0, 16'd0);
    drain();
    write_reg(act_pkg::REG_INIT_LEVEL, 32'hFFFF_FFFF);
    write_reg(act_pkg::REG_MIN_MOTION, 32'hFFFF_FFFF);
    write_reg(act_pkg::REG_RANGE_SCALE, 32'd0);
    send_dev(32'd7, 32'd0, 32'd0, 16'h7FFF, 16'd0, 16'd0);
    drain();

    // Random phases, each with its own settings and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      write_reg(act_pkg::REG_INIT_LEVEL, (ph == 7) ? 32'd0 : $urandom_range(1 << 20));
      write_reg(act_pkg::REG_MIN_MOTION, (ph == 6) ? 32'd0 : $urandom_range(1 << 18));
      write_reg(act_pkg::REG_RANGE_SCALE,
                (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(1 << 24));
      write_reg(act_pkg::REG_AVERAGE_WEIGHT, (ph % 2) ? $urandom_range(65535) : 32'd0);
      for (int i = 0; i < 53; i++) begin
        send_random();
        // Hold off the sender once until every result is back.
        if (ph == 3 && i == 20) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("adaptive_correspondence_threshold test passed");
    end else begin
      $display("adaptive_correspondence_threshold test failed");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/act_pkg.sv
sv/act_mul.sv
sv/act_isqrt.sv
sv/act_div.sv
sv/adaptive_correspondence_threshold.sv
tb/sv/act_checker.sv
tb/sv/testbench.sv
